// ===== design/form_field_extract_percent_decode_top_assert.svh =====
// Assertion macros for the form field extractor checks.
// Each macro expects clk_i and rst_ni in scope.
`ifndef FORM_FIELD_EXTRACT_PERCENT_DECODE_TOP_ASSERT_SVH
`define FORM_FIELD_EXTRACT_PERCENT_DECODE_TOP_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define FFE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ffe check failed");

// Next-cycle implication, off while in reset.
`define FFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ffe check failed");

`endif

// ===== design/ffe_pkg.sv =====
// ----------------------------------------------------------------------------
// ffe_pkg
// Types, constants and helpers shared by the form field extractor.
// ----------------------------------------------------------------------------
package ffe_pkg;

  localparam int unsigned KeyMaxBytes    = 16;
  localparam int unsigned RawBufferBytes = 256;
  localparam int unsigned RawCntW        = $clog2(RawBufferBytes);
  localparam int unsigned KeyIdxW        = $clog2(KeyMaxBytes + 1);
  localparam int unsigned MaxResults     = 4;
  localparam int unsigned ResCntW        = $clog2(MaxResults + 1);
  localparam int unsigned ResIdxW        = $clog2(MaxResults);
  localparam int unsigned CfgIdxW        = 8;

  // Character codes
  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChEq      = 8'h3D;
  localparam logic [7:0] ChDigit0  = 8'h30;
  localparam logic [7:0] ChDigit9  = 8'h39;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperF  = 8'h46;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerF  = 8'h66;
  localparam logic [7:0] HexAlphaBase = 8'd10;

  // Register reset values
  localparam logic [4:0] KeyLengthRst = 5'd4;
  localparam logic [7:0] MaxValueRst  = 8'd32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_LOW  = 8'd0,
    CFG_KEY_HIGH = 8'd1,
    CFG_KEY_LEN  = 8'd2,
    CFG_MAX_VAL  = 8'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_MATCH,
    PH_SKIP,
    PH_VALUE,
    PH_IDLE
  } scan_phase_e;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       is_data;
    logic       key_found;
    logic       done_res;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key_bytes_low;
    logic [63:0] key_bytes_high;
    logic [4:0]  key_length;
    logic [7:0]  max_value_bytes;
  } cfg_t;

  typedef struct packed {
    scan_phase_e          phase;
    logic [KeyIdxW-1:0]   key_idx;
    logic [RawCntW-1:0]   raw_cnt;
    logic [7:0]           dec_cnt;
    logic                 pend_pct;
    logic                 pend_hex_vld;
    logic [7:0]           pend_hex;
    logic                 finished;
  } scan_state_t;

  typedef struct packed {
    out_item_t [MaxResults-1:0] item;
    logic [ResCntW-1:0]         count;
  } step_res_t;

  localparam scan_state_t ScanReset = '{
    phase:        PH_MATCH,
    key_idx:      '0,
    raw_cnt:      '0,
    dec_cnt:      '0,
    pend_pct:     1'b0,
    pend_hex_vld: 1'b0,
    pend_hex:     '0,
    finished:     1'b0
  };

  function automatic logic is_hex(logic [7:0] c);
    return ((c >= ChDigit0) && (c <= ChDigit9)) ||
           ((c >= ChLowerA) && (c <= ChLowerF)) ||
           ((c >= ChUpperA) && (c <= ChUpperF));
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] v;
    v = '0;
    if ((c >= ChDigit0) && (c <= ChDigit9)) begin
      v = c - ChDigit0;
    end else if ((c >= ChLowerA) && (c <= ChLowerF)) begin
      v = c - ChLowerA + HexAlphaBase;
    end else if ((c >= ChUpperA) && (c <= ChUpperF)) begin
      v = c - ChUpperA + HexAlphaBase;
    end
    return v[3:0];
  endfunction

endpackage

// ===== design/ffe_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ffe_cfg_regs
// Configuration register file: key bytes, key length and output capacity.
// ----------------------------------------------------------------------------
module ffe_cfg_regs import ffe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Always take a write request
  assign cfg_ready_o = 1'b1;

  // Decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_KEY_LOW:  cfg_d.key_bytes_low   = cfg_data_i;
        CFG_KEY_HIGH: cfg_d.key_bytes_high  = cfg_data_i;
        CFG_KEY_LEN:  cfg_d.key_length      = cfg_data_i[4:0];
        CFG_MAX_VAL:  cfg_d.max_value_bytes = cfg_data_i[7:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_bytes_low   <= '0;
      cfg_q.key_bytes_high  <= '0;
      cfg_q.key_length      <= KeyLengthRst;
      cfg_q.max_value_bytes <= MaxValueRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/ffe_scan.sv =====
// ----------------------------------------------------------------------------
// ffe_scan
// Scanner state and single-pass step logic: key match, value decode and
// the result list that one body byte produces.
// ----------------------------------------------------------------------------
module ffe_scan import ffe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output step_res_t res_o
);

  scan_state_t state_q, state_d, mid;

  logic [7:0]                  b;
  logic [KeyIdxW-1:0]          klen;
  logic [7:0]                  key_ch;
  logic [MaxResults-1:0][7:0]  cand;
  logic [ResIdxW-1:0]          ncand;
  logic                        do_plain;
  logic                        close_v;
  logic                        mark_v;
  logic                        mark_found;
  logic [7:0]                  room;
  logic [ResIdxW-1:0]          nemit;

  assign b = item_i.body_byte;

  // Clamp key length to the key storage
  assign klen = (cfg_i.key_length > KeyIdxW'(KeyMaxBytes)) ?
                KeyIdxW'(KeyMaxBytes) : cfg_i.key_length;

  // Select the expected key character
  always_comb begin
    if (state_q.key_idx[3]) begin
      key_ch = cfg_i.key_bytes_high[{state_q.key_idx[2:0], 3'b000} +: 8];
    end else begin
      key_ch = cfg_i.key_bytes_low[{state_q.key_idx[2:0], 3'b000} +: 8];
    end
  end

  // Advance the scanner by one byte and collect decoded candidates
  always_comb begin
    mid        = state_q;
    cand       = '0;
    ncand      = '0;
    do_plain   = 1'b0;
    close_v    = 1'b0;
    mark_v     = 1'b0;
    mark_found = 1'b0;

    unique case (state_q.phase)
      PH_MATCH: begin
        if (b == ChNul) begin
          mid.phase = PH_IDLE;
        end else if (state_q.key_idx < klen) begin
          if (b == key_ch) begin
            mid.key_idx = state_q.key_idx + 1'b1;
          end else if (b == ChAmp) begin
            mid.key_idx = '0;
          end else begin
            mid.phase = PH_SKIP;
          end
        end else if (b == ChEq) begin
          mid.phase        = PH_VALUE;
          mid.raw_cnt      = '0;
          mid.dec_cnt      = '0;
          mid.pend_pct     = 1'b0;
          mid.pend_hex_vld = 1'b0;
          mid.pend_hex     = '0;
        end else if (b == ChAmp) begin
          mid.key_idx = '0;
        end else begin
          mid.phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (b == ChNul) begin
          mid.phase = PH_IDLE;
        end else if (b == ChAmp) begin
          mid.phase   = PH_MATCH;
          mid.key_idx = '0;
        end
      end
      PH_VALUE: begin
        if ((b == ChNul) || (b == ChAmp)) begin
          close_v = 1'b1;
        end else if (state_q.raw_cnt < RawCntW'(RawBufferBytes - 1)) begin
          mid.raw_cnt = state_q.raw_cnt + 1'b1;
          if (state_q.pend_pct) begin
            if (!state_q.pend_hex_vld) begin
              if (is_hex(b)) begin
                // hold first hex digit
                mid.pend_hex_vld = 1'b1;
                mid.pend_hex     = b;
              end else begin
                // lone percent passes through
                cand[ncand]      = ChPercent;
                ncand            = ncand + 1'b1;
                mid.pend_pct     = 1'b0;
                mid.pend_hex_vld = 1'b0;
                mid.pend_hex     = '0;
                do_plain         = 1'b1;
              end
            end else if (is_hex(b)) begin
              // full escape: two digits make one byte
              cand[ncand]      = {hex_val(state_q.pend_hex), hex_val(b)};
              ncand            = ncand + 1'b1;
              mid.pend_pct     = 1'b0;
              mid.pend_hex_vld = 1'b0;
              mid.pend_hex     = '0;
            end else begin
              // broken escape: percent and held digit pass through
              cand[ncand]      = ChPercent;
              ncand            = ncand + 1'b1;
              cand[ncand]      = state_q.pend_hex;
              ncand            = ncand + 1'b1;
              mid.pend_pct     = 1'b0;
              mid.pend_hex_vld = 1'b0;
              mid.pend_hex     = '0;
              do_plain         = 1'b1;
            end
          end else begin
            do_plain = 1'b1;
          end
        end
      end
      PH_IDLE: begin
        mid = state_q;
      end
      default: begin
        mid = state_q;
      end
    endcase

    // Plain byte handling
    if (do_plain) begin
      if (b == ChPlus) begin
        cand[ncand] = ChSpace;
        ncand       = ncand + 1'b1;
      end else if (b == ChPercent) begin
        mid.pend_pct = 1'b1;
      end else begin
        cand[ncand] = b;
        ncand       = ncand + 1'b1;
      end
    end

    // Close the value: flush pending escape, then the found marker
    if (close_v || (item_i.body_last && (mid.phase == PH_VALUE))) begin
      if (mid.pend_pct) begin
        cand[ncand] = ChPercent;
        ncand       = ncand + 1'b1;
        if (mid.pend_hex_vld) begin
          cand[ncand] = mid.pend_hex;
          ncand       = ncand + 1'b1;
        end
      end
      mid.pend_pct     = 1'b0;
      mid.pend_hex_vld = 1'b0;
      mid.pend_hex     = '0;
      mid.finished     = 1'b1;
      mid.phase        = PH_IDLE;
      mark_v           = 1'b1;
      mark_found       = 1'b1;
    end else if (item_i.body_last && !mid.finished) begin
      mark_v = 1'b1;
    end
  end

  // Saturate data at the output capacity
  always_comb begin
    room  = (cfg_i.max_value_bytes > mid.dec_cnt) ?
            (cfg_i.max_value_bytes - mid.dec_cnt) : 8'd0;
    nemit = (room < {{(8 - ResIdxW){1'b0}}, ncand}) ? room[ResIdxW-1:0] : ncand;
  end

  // Build the result list and the next state
  always_comb begin
    state_d         = mid;
    state_d.dec_cnt = mid.dec_cnt + {{(8 - ResIdxW){1'b0}}, nemit};
    if (item_i.body_last) begin
      state_d = ScanReset;
    end

    for (int i = 0; i < MaxResults; i++) begin
      res_o.item[i] = '{value_byte: cand[i], is_data: 1'b1,
                        key_found: 1'b0, done_res: 1'b0};
    end
    if (mark_v) begin
      res_o.item[nemit] = '{value_byte: ChNul, is_data: 1'b0,
                            key_found: mark_found, done_res: 1'b1};
    end
    res_o.count = ResCntW'(nemit) + ResCntW'(mark_v);
  end

  // Hold the scanner state between bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ScanReset;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/ffe_result_buf.sv =====
// ----------------------------------------------------------------------------
// ffe_result_buf
// Result register: takes the result list of one step and drains it one
// request per cycle on the output channel while the output is ready.
// ----------------------------------------------------------------------------
module ffe_result_buf import ffe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  step_res_t res_i,
  output logic      can_load_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  out_item_t [MaxResults-1:0] item_q;
  logic [ResIdxW-1:0]         rd_q;
  logic [ResCntW-1:0]         cnt_q;
  logic                       pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = item_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;

  // Free for a new list once the last held result leaves
  assign can_load_o = (cnt_q == '0) || ((cnt_q == ResCntW'(1)) && out_ready_i);

  // Payload: load the whole list
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= res_i.item;
    end
  end

  // Advance the read pointer and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      cnt_q <= '0;
    end else if (load_i) begin
      rd_q  <= '0;
      cnt_q <= res_i.count;
    end else if (pop) begin
      rd_q  <= rd_q + 1'b1;
      cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== design/form_field_extract_percent_decode_top.sv =====
// A body byte passes the input register and the result register before its
// first result shows on the output; further results follow one per cycle
// while the output is ready. Throughput: one byte per cycle while each byte
// gives at most one result and the output is ready; else the input side
// holds while the result buffer drains (up to 4 results). Reset clears the
// scanner, empties the buffers and loads key length 4 and capacity 32.
// ----------------------------------------------------------------------------
// form_field_extract_percent_decode_top
// Streams an urlencoded form body, finds the configured key and emits its
// percent-decoded value followed by an end marker.
// ----------------------------------------------------------------------------
module form_field_extract_percent_decode_top import ffe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  cfg_t      cfg;
  step_res_t step_res;
  in_item_t  in_q;
  logic      in_valid_q;
  logic      can_load;
  logic      step;

  // Step the scanner when a byte is held and the result buffer frees up
  assign step       = in_valid_q && can_load;
  assign in_ready_o = !in_valid_q || step;

  // Input register: payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  // Input register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  ffe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ffe_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  ffe_result_buf u_res (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (step_res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== design/ffe_port_chk.sv =====
// ----------------------------------------------------------------------------
// ffe_port_chk
// Port-level checks for the form field extractor, bound to the top level.
// ----------------------------------------------------------------------------
`include "form_field_extract_percent_decode_top_assert.svh"

module ffe_port_chk import ffe_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input out_item_t          out_item_o
);

  // Data results carry no end flags
  `FFE_ASSERT_SAME(a_data_flags, out_valid_o && out_item_o.is_data, !out_item_o.key_found && !out_item_o.done_res)

  // End marker closes the body with a zero byte
  `FFE_ASSERT_SAME(a_marker_form, out_valid_o && !out_item_o.is_data, out_item_o.done_res && (out_item_o.value_byte == ChNul))

  // Input side stalls only behind a waiting result
  `FFE_ASSERT_SAME(a_stall_cause, !in_ready_o, out_valid_o)

  // A stalled result request holds
  `FFE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))

endmodule

bind form_field_extract_percent_decode_top ffe_port_chk u_ffe_port_chk (.*);
